// ----- sv/fifo_vertex_cache_miss_counter_defines.svh -----
// Assertion macros used by the checker of the vertex cache miss counter
`ifndef FIFO_VERTEX_CACHE_MISS_COUNTER_DEFINES_SVH
`define FIFO_VERTEX_CACHE_MISS_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FVCMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define FVCMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fvcmc_pkg.sv -----
// Shared constants and types of the vertex cache miss counter
`timescale 1ns / 1ps
`default_nettype none

package fvcmc_pkg;

    localparam int CACHE_DEPTH_DEF = 32;
    localparam int VERTEX_BITS_DEF = 16;

    localparam int IN_W   = 16;
    localparam int SIZE_W = 6;
    localparam int MISS_W = 32;
    localparam int DIST_W = 17;

    localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;

    localparam int ROW_SEL_W = 5;
    localparam int ROW_BITS  = 1 << ROW_SEL_W;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic              hit;
        logic [MISS_W-1:0] miss_count;
        logic [DIST_W-1:0] distinct_count;
    } res_t;

endpackage

`default_nettype wire

// ----- sv/fvcmc_queue.sv -----
// Small register queue with push/full and pop/empty sides
`timescale 1ns / 1ps
`default_nettype none

module fvcmc_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = fvcmc_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/fvcmc_front.sv -----
// Front end: take vertex indices, trim them to the index width, and buffer them
`timescale 1ns / 1ps
`default_nettype none

module fvcmc_front #(
    parameter int VERTEX_BITS = fvcmc_pkg::VERTEX_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [fvcmc_pkg::IN_W-1:0]   vertex_index,
    output logic                              full,
    input  wire logic                         pop,
    output logic      [VERTEX_BITS-1:0]       vertex,
    output logic                              empty
);

    logic [VERTEX_BITS-1:0] vertex_trim;

    // drop index bits above the configured index width
    assign vertex_trim = VERTEX_BITS'(vertex_index);

    fvcmc_queue #(
        .WIDTH (VERTEX_BITS),
        .DEPTH (fvcmc_pkg::QUEUE_DEPTH)
    ) u_in_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (vertex_trim),
        .full    (full),
        .pop     (pop),
        .rd_data (vertex),
        .empty   (empty)
    );

endmodule

`default_nettype wire

// ----- sv/fvcmc_back.sv -----
// Back end: seen-map memory, FIFO cache lookup and update, running counters
`timescale 1ns / 1ps
`default_nettype none

module fvcmc_back #(
    parameter int CACHE_DEPTH = fvcmc_pkg::CACHE_DEPTH_DEF,
    parameter int VERTEX_BITS = fvcmc_pkg::VERTEX_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [fvcmc_pkg::SIZE_W-1:0]   size_limit,
    input  wire logic                           q_empty,
    input  wire logic [VERTEX_BITS-1:0]         q_vertex,
    output logic                                q_pop,
    input  wire logic                           res_full,
    output logic                                res_push,
    output fvcmc_pkg::res_t                     res_data
);

    localparam int FILL_W = $clog2(CACHE_DEPTH + 1);
    localparam int CMP_W  = ((FILL_W > fvcmc_pkg::SIZE_W) ? FILL_W : fvcmc_pkg::SIZE_W) + 1;
    localparam int ROW_AW = VERTEX_BITS - fvcmc_pkg::ROW_SEL_W;
    localparam int ROWS   = 1 << ROW_AW;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_CLEAR = 2'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 2'd1;
    localparam logic [ST_W-1:0] ST_UPD   = 2'd2;

    logic [fvcmc_pkg::ROW_BITS-1:0]  seen_mem [ROWS];
    logic [fvcmc_pkg::ROW_BITS-1:0]  row_reg;
    logic [VERTEX_BITS-1:0]          v_reg;
    logic [VERTEX_BITS-1:0]          entries_reg [CACHE_DEPTH];

    logic [ST_W-1:0]                 st_reg, st_next;
    logic [ROW_AW-1:0]               clr_reg, clr_next;
    logic [FILL_W-1:0]               fill_reg, fill_next;
    logic [fvcmc_pkg::MISS_W-1:0]    miss_reg, miss_next;
    logic [fvcmc_pkg::DIST_W-1:0]    dist_reg, dist_next;

    logic                            upd;
    logic [fvcmc_pkg::ROW_SEL_W-1:0] bit_off;
    logic                            seen;
    logic [CACHE_DEPTH-1:0]          match;
    logic                            hit;
    logic                            mem_we;
    logic [ROW_AW-1:0]               mem_wa;
    logic [fvcmc_pkg::ROW_BITS-1:0]  mem_wd;
    logic [CMP_W-1:0]                eff_size;
    logic [CMP_W-1:0]                fill_inc;
    logic [CMP_W-1:0]                fill_adj;
    logic [fvcmc_pkg::MISS_W-1:0]    miss_upd;
    logic [fvcmc_pkg::DIST_W-1:0]    dist_upd;

    assign upd     = (st_reg == ST_UPD);
    assign q_pop   = (st_reg == ST_IDLE) && !q_empty && !res_full;
    assign bit_off = v_reg[fvcmc_pkg::ROW_SEL_W-1:0];
    assign seen    = row_reg[bit_off];

    always_comb
    begin
        for (int i = 0; i < CACHE_DEPTH; i++)
        begin
            match[i] = (CMP_W'(i) < CMP_W'(fill_reg)) && (entries_reg[i] == v_reg);
        end
    end

    assign hit = |match;

    always_comb
    begin
        eff_size = (CMP_W'(size_limit) > CMP_W'(CACHE_DEPTH))
                   ? CMP_W'(CACHE_DEPTH) : CMP_W'(size_limit);
        fill_inc = CMP_W'(fill_reg) + 1'b1;
        fill_adj = (fill_inc > eff_size) ? CMP_W'(fill_reg) : fill_inc;
        if (fill_adj > CMP_W'(CACHE_DEPTH))
        begin
            fill_adj = CMP_W'(CACHE_DEPTH);
        end
    end

    assign miss_upd = hit ? miss_reg
                    : ((miss_reg != '1) ? miss_reg + 1'b1 : miss_reg);
    assign dist_upd = seen ? dist_reg
                    : ((dist_reg != '1) ? dist_reg + 1'b1 : dist_reg);

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = v_reg[VERTEX_BITS-1:fvcmc_pkg::ROW_SEL_W];
        mem_wd = row_reg | (fvcmc_pkg::ROW_BITS'(1) << bit_off);
        if (st_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = '0;
        end
        else if (upd && !seen)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        clr_next  = clr_reg;
        fill_next = fill_reg;
        miss_next = miss_reg;
        dist_next = dist_reg;
        case (st_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    st_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                st_next   = ST_IDLE;
                miss_next = miss_upd;
                dist_next = dist_upd;
                if (!hit)
                begin
                    fill_next = FILL_W'(fill_adj);
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_CLEAR;
            clr_reg  <= '0;
            fill_reg <= '0;
            miss_reg <= '0;
            dist_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            clr_reg  <= clr_next;
            fill_reg <= fill_next;
            miss_reg <= miss_next;
            dist_reg <= dist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            row_reg <= seen_mem[q_vertex[VERTEX_BITS-1:fvcmc_pkg::ROW_SEL_W]];
            v_reg   <= q_vertex;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            seen_mem[mem_wa] <= mem_wd;
        end
    end

    // insert at the newest end on a miss
    always_ff @(posedge clk)
    begin
        if (upd && !hit)
        begin
            entries_reg[0] <= v_reg;
            for (int i = 1; i < CACHE_DEPTH; i++)
            begin
                entries_reg[i] <= entries_reg[i-1];
            end
        end
    end

    assign res_push                = upd;
    assign res_data.hit            = hit;
    assign res_data.miss_count     = miss_upd;
    assign res_data.distinct_count = dist_upd;

endmodule

`default_nettype wire

// ----- sv/fifo_vertex_cache_miss_counter.sv -----
// Top level of the FIFO vertex cache miss counter.
// Vertex indices go in through a push/full queue port; for each one a result
// (hit flag, saturating miss total, distinct vertex total) comes out through a
// pop/empty queue port in input order. The back end handles one item at a time:
// in its idle state it reads the seen-map row of the index, then in its update
// state it writes the row back and updates the cache, before it takes the next;
// it waits in its idle state while the result queue is full. After reset the
// back end clears the seen map one 32-bit row a cycle, over 2^VERTEX_BITS/32
// rows (2048 at the default); up to two items are buffered meanwhile and wait.
// The cache size register (reset 32, values above CACHE_DEPTH act as
// CACHE_DEPTH) is written through cfg_valid/cfg_data, always ready;
// write it before the first item.
`timescale 1ns / 1ps
`default_nettype none

module fifo_vertex_cache_miss_counter #(
    parameter int CACHE_DEPTH = fvcmc_pkg::CACHE_DEPTH_DEF,
    parameter int VERTEX_BITS = fvcmc_pkg::VERTEX_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [fvcmc_pkg::IN_W-1:0]     vertex_index,
    input  wire logic                           pop,
    output logic                                empty,
    output logic                                hit,
    output logic      [fvcmc_pkg::MISS_W-1:0]   miss_count,
    output logic      [fvcmc_pkg::DIST_W-1:0]   distinct_count,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fvcmc_pkg::SIZE_W-1:0]   cfg_data
);

    logic [fvcmc_pkg::SIZE_W-1:0] size_reg;
    logic [VERTEX_BITS-1:0]       mid_vertex;
    logic                         mid_empty;
    logic                         mid_pop;
    logic                         res_full;
    logic                         res_push;
    fvcmc_pkg::res_t              res_in;
    fvcmc_pkg::res_t              res_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= fvcmc_pkg::SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    fvcmc_front #(
        .VERTEX_BITS (VERTEX_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .vertex_index (vertex_index),
        .full         (full),
        .pop          (mid_pop),
        .vertex       (mid_vertex),
        .empty        (mid_empty)
    );

    fvcmc_back #(
        .CACHE_DEPTH (CACHE_DEPTH),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .size_limit (size_reg),
        .q_empty    (mid_empty),
        .q_vertex   (mid_vertex),
        .q_pop      (mid_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_in)
    );

    fvcmc_queue #(
        .WIDTH ($bits(fvcmc_pkg::res_t)),
        .DEPTH (fvcmc_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign hit            = res_out.hit;
    assign miss_count     = res_out.miss_count;
    assign distinct_count = res_out.distinct_count;

endmodule

`default_nettype wire

// ----- sv/fvcmc_checker.sv -----
// Port-level checker of the vertex cache miss counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_vertex_cache_miss_counter_defines.svh"

module fvcmc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           pop,
    input wire logic                           empty,
    input wire logic                           hit,
    input wire logic [fvcmc_pkg::MISS_W-1:0]   miss_count,
    input wire logic [fvcmc_pkg::DIST_W-1:0]   distinct_count
);

    logic [fvcmc_pkg::MISS_W-1:0] last_miss_reg, last_miss_next;
    logic [fvcmc_pkg::DIST_W-1:0] last_dist_reg, last_dist_next;
    logic                         xfer;
    logic [fvcmc_pkg::MISS_W:0]   miss_step;
    logic [fvcmc_pkg::DIST_W:0]   dist_step;
    logic [fvcmc_pkg::DIST_W:0]   dist_now;
    logic [fvcmc_pkg::DIST_W:0]   dist_last;
    logic [fvcmc_pkg::MISS_W:0]   miss_now;

    assign xfer           = pop && !empty;
    assign last_miss_next = xfer ? miss_count : last_miss_reg;
    assign last_dist_next = xfer ? distinct_count : last_dist_reg;
    assign miss_step      = (fvcmc_pkg::MISS_W + 1)'(last_miss_reg) + 1'b1;
    assign miss_now       = (fvcmc_pkg::MISS_W + 1)'(miss_count);
    assign dist_last      = (fvcmc_pkg::DIST_W + 1)'(last_dist_reg);
    assign dist_step      = dist_last + 1'b1;
    assign dist_now       = (fvcmc_pkg::DIST_W + 1)'(distinct_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_miss_reg <= '0;
            last_dist_reg <= '0;
        end
        else
        begin
            last_miss_reg <= last_miss_next;
            last_dist_reg <= last_dist_next;
        end
    end

    `FVCMC_ASSERT_NXT(a_result_holds, clk, rst_n, !empty && !pop, !empty, "result withdrawn before transfer")
    `FVCMC_ASSERT_NXT(a_result_stable, clk, rst_n, !empty && !pop, $stable(miss_count) && $stable(distinct_count) && $stable(hit), "result changed before transfer")
    `FVCMC_ASSERT_IMP(a_hit_keeps_misses, clk, rst_n, xfer && hit, miss_count == last_miss_reg, "hit changed the miss count")
    `FVCMC_ASSERT_IMP(a_miss_counts, clk, rst_n, xfer && !hit && last_miss_reg != '1, miss_now == miss_step, "miss did not raise the miss count by one")
    `FVCMC_ASSERT_IMP(a_distinct_step, clk, rst_n, xfer, dist_now >= dist_last && dist_now <= dist_step, "distinct count moved by more than one")

endmodule

bind fifo_vertex_cache_miss_counter fvcmc_checker u_fvcmc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop            (pop),
    .empty          (empty),
    .hit            (hit),
    .miss_count     (miss_count),
    .distinct_count (distinct_count)
);

`default_nettype wire

// ----- sim/tb_fifo_vertex_cache_miss_counter.sv -----
// Self-checking testbench for the FIFO vertex cache miss counter: queue-style stimulus and checks
`timescale 1ns / 1ps

module tb_fifo_vertex_cache_miss_counter;

    localparam int DEPTH    = fvcmc_pkg::CACHE_DEPTH_DEF;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 183;

    logic                           clk;
    logic                           rst_n;
    logic                           push;
    logic                           full;
    logic [fvcmc_pkg::IN_W-1:0]     vertex_index;
    logic                           pop;
    logic                           empty;
    logic                           hit;
    logic [fvcmc_pkg::MISS_W-1:0]   miss_count;
    logic [fvcmc_pkg::DIST_W-1:0]   distinct_count;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [fvcmc_pkg::SIZE_W-1:0]   cfg_data;

    fifo_vertex_cache_miss_counter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .vertex_index   (vertex_index),
        .pop            (pop),
        .empty          (empty),
        .hit            (hit),
        .miss_count     (miss_count),
        .distinct_count (distinct_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // predicted cache state
    logic [fvcmc_pkg::IN_W-1:0]     cache_line [DEPTH];
    int                             line_fill = 0;
    logic [fvcmc_pkg::MISS_W-1:0]   miss_total = '0;
    logic [fvcmc_pkg::DIST_W-1:0]   distinct_total = '0;
    bit                             visited [0:65535];
    logic [fvcmc_pkg::SIZE_W-1:0]   size_reg = fvcmc_pkg::SIZE_RST;

    logic [fvcmc_pkg::IN_W-1:0]     vertex_stream [$];
    fvcmc_pkg::res_t                predicted_lookups [$];
    logic [fvcmc_pkg::IN_W-1:0]     recent_vertices [$];
    logic [fvcmc_pkg::IN_W-1:0]     strip_base;

    bit   item_taken = 1'b0;
    bit   cfg_taken = 1'b0;
    bit   hold_off = 1'b0;
    int   idle_pct = 31;
    int   accepted_items = 0;
    int   checked_results = 0;
    int   hit_total = 0;
    int   size_settings = 0;
    int   error_count = 0;

    int   size_plan [N_PHASES] = '{63, 4, 32, 0, 33, 1, 17, 2, 31, 32};

    function automatic fvcmc_pkg::res_t predict_lookup(input logic [fvcmc_pkg::IN_W-1:0] v);
        fvcmc_pkg::res_t r;
        bit found;
        int i;
        int top;
        int limit;
        int next_fill;
        found = 1'b0;
        if (!visited[v])
        begin
            visited[v] = 1'b1;
            if (distinct_total != '1)
                distinct_total++;
        end
        for (i = 0; i < line_fill; i++)
            if (cache_line[i] == v)
                found = 1'b1;
        if (!found)
        begin
            top = (line_fill < DEPTH) ? line_fill : DEPTH - 1;
            for (i = top; i > 0; i--)
                cache_line[i] = cache_line[i-1];
            cache_line[0] = v;
            limit = (size_reg > DEPTH) ? DEPTH : size_reg;
            next_fill = line_fill + 1;
            if (next_fill > limit)
                next_fill--;
            if (next_fill > DEPTH)
                next_fill = DEPTH;
            line_fill = next_fill;
            if (miss_total != '1)
                miss_total++;
        end
        r.hit = found;
        r.miss_count = miss_total;
        r.distinct_count = distinct_total;
        return r;
    endfunction

    function automatic logic [fvcmc_pkg::IN_W-1:0] next_vertex(input int span);
        int pick;
        logic [fvcmc_pkg::IN_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            v = fvcmc_pkg::IN_W'($urandom_range(0, 65535));
        else if (pick < 40 && recent_vertices.size() > 0)
            v = recent_vertices[$urandom_range(0, recent_vertices.size() - 1)];
        else
        begin
            if ($urandom_range(0, 7) == 0)
                strip_base = strip_base + fvcmc_pkg::IN_W'($urandom_range(1, 4));
            v = strip_base + fvcmc_pkg::IN_W'($urandom_range(0, span));
        end
        recent_vertices = {recent_vertices, v};
        if (recent_vertices.size() > 6)
            void'(recent_vertices.pop_front());
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic write_size_limit(input logic [fvcmc_pkg::SIZE_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(negedge clk); while (!cfg_taken);
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    task automatic wait_drained;
        do @(negedge clk); while (vertex_stream.size() != 0 || predicted_lookups.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    // offer the head of the pending stream; hold it until the transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!push || item_taken)
            begin
                if (vertex_stream.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    push         <= 1'b1;
                    vertex_index <= vertex_stream[0];
                end
                else
                begin
                    push         <= 1'b0;
                    vertex_index <= fvcmc_pkg::IN_W'($urandom_range(0, 65535));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            pop <= !hold_off && ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge clk)
    begin : observe
        fvcmc_pkg::res_t want;
        if (rst_n)
        begin
            item_taken <= push && !full;
            cfg_taken  <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
                size_reg = cfg_data;
            if (push && !full)
            begin
                void'(vertex_stream.pop_front());
                predicted_lookups = {predicted_lookups, predict_lookup(vertex_index)};
                accepted_items++;
            end
            if (pop && !empty)
            begin
                if (predicted_lookups.size() == 0)
                    report_mismatch("result transfer with no lookup outstanding");
                else
                begin
                    want = predicted_lookups.pop_front();
                    checked_results++;
                    if (hit !== want.hit)
                        report_mismatch($sformatf("result %0d hit: got %b, want %b",
                                                  checked_results, hit, want.hit));
                    if (miss_count !== want.miss_count)
                        report_mismatch($sformatf("result %0d miss_count: got %0d, want %0d",
                                                  checked_results, miss_count,
                                                  want.miss_count));
                    if (distinct_count !== want.distinct_count)
                        report_mismatch($sformatf("result %0d distinct_count: got %0d, want %0d",
                                                  checked_results, distinct_count,
                                                  want.distinct_count));
                    if (want.hit)
                        hit_total++;
                end
            end
        end
    end

    // hold off the receiver so the block fills up and stalls its input
    initial
    begin
        wait (accepted_items >= 700 && vertex_stream.size() > 100);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : stimulus
        int p;
        int n;
        int span;
        int limit;
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        vertex_index = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        strip_base   = fvcmc_pkg::IN_W'($urandom_range(0, 65535));
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        write_size_limit(6'd32);
        vertex_stream = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                          16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
        wait_drained;

        write_size_limit(6'd0);
        vertex_stream = '{16'h0003, 16'h0003, 16'h0000};
        wait_drained;

        write_size_limit(6'd1);
        vertex_stream = '{16'h0009, 16'h0009, 16'h000A, 16'h0009, 16'h000A};
        wait_drained;

        write_size_limit(6'd63);
        vertex_stream = '{16'h8000, 16'h0001, 16'h8000};
        wait_drained;

        for (p = 0; p < N_PHASES; p++)
        begin
            write_size_limit(fvcmc_pkg::SIZE_W'(size_plan[p]));
            idle_pct = (p == 2) ? 0 : 31;
            limit = (size_plan[p] > DEPTH) ? DEPTH : size_plan[p];
            span = limit + limit / 2 + 3;
            strip_base = fvcmc_pkg::IN_W'($urandom_range(0, 65535));
            for (n = 0; n < PHASE_ITEMS; n++)
                vertex_stream = {vertex_stream, next_vertex(span)};
            wait_drained;
        end
        idle_pct = 31;

        repeat (12) @(negedge clk);
        $display("Covered %0d lookups over %0d cache size settings, sizes 0 through 63.",
                 accepted_items, size_settings);
        $display("Checked %0d results: %0d hits, %0d misses, %0d distinct vertices.",
                 checked_results, hit_total, miss_total, distinct_total);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
